// ===== rtl/core/dts_pkg.sv =====
// shared types, constants and the quarter-wave sine table of the tone synthesiser
// used by dts_sine_rom and decaying_tone_synth_core; depends on nothing else
package dts_pkg;

	// sine table geometry
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
	localparam int QTR_W            = $clog2(QTR_DEPTH);

	// attack ramp: level steps by 2^24 / ATTACK_SAMPLES, remainder carried exactly
	localparam int ATTACK_SAMPLES = 96;
	localparam int ATT_REM_W      = (ATTACK_SAMPLES > 1) ? $clog2(ATTACK_SAMPLES) : 1;
	localparam int ATT_Q          = (2 ** 24) / ATTACK_SAMPLES;
	localparam int ATT_R          = (2 ** 24) % ATTACK_SAMPLES;

	// field widths
	localparam int PHASE_W = 32;
	localparam int STEP_W  = 31;
	localparam int COUNT_W = 21;
	localparam int LEN_W   = 20;
	localparam int ENV_W   = 25;
	localparam int DECAY_W = 24;
	localparam int GAIN_W  = 16;
	localparam int NUM_W   = 20;
	localparam int MAG_W   = 15;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// final scaling of mix * gain * level down to the sample
	localparam int OUT_SH = 40;

	localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(2 ** 24);

	// harmonic mix divisor, replaced by a reciprocal multiply
	localparam int MIX_SH  = 24;
	localparam int MIX_DIV = 13;
	localparam int RCP_MIX = (2 ** MIX_SH + MIX_DIV - 1) / MIX_DIV;

	// register map
	localparam int CFG_ADDR_W = 5;
	localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
	localparam logic [2:0] REG_NOTE_SAMPLES = 3'd1;
	localparam logic [2:0] REG_GAP_SAMPLES  = 3'd2;
	localparam logic [2:0] REG_DECAY_MULT   = 3'd3;
	localparam logic [2:0] REG_GAIN         = 3'd4;

	// per-note state word held in the state memory
	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [COUNT_W-1:0]   count;
		logic [ENV_W-1:0]     env;
		logic [ENV_W-1:0]     alvl;
		logic [ATT_REM_W-1:0] arem;
	} dts_state_t;

	typedef logic [MAG_W-1:0] sine_tab_t [QTR_DEPTH+1];

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;

	// quarter-wave magnitudes, built at elaboration with an integer taylor series
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t         tab;
		longint unsigned   t;
		longint unsigned   t2;
		longint unsigned   term;
		longint unsigned   s;
		longint unsigned   v;
		longint            sum;
		for (int j = 0; j <= QTR_DEPTH; j++) begin
			t    = (HALF_PI_Q30 * longint'(4 * j)) / SINE_TABLE_DEPTH;
			t2   = (t * t) >> 30;
			term = t;
			sum  = longint'(t);
			term = ((term * t2) >> 30) / 6;
			sum  = sum - longint'(term);
			term = ((term * t2) >> 30) / 20;
			sum  = sum + longint'(term);
			term = ((term * t2) >> 30) / 42;
			sum  = sum - longint'(term);
			term = ((term * t2) >> 30) / 72;
			sum  = sum + longint'(term);
			term = ((term * t2) >> 30) / 110;
			sum  = sum - longint'(term);
			if (sum < 0)
				sum = 0;
			s = longint'(sum);
			if (s > ONE_Q30)
				s = ONE_Q30;
			v = (s * 32767 + (ONE_Q30 >> 1)) >> 30;
			tab[j] = MAG_W'(v);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/decaying_tone_synth_core.sv =====
// top level of the decaying tone synthesiser: apb registers, sequencer, shared multiplier
// depends on dts_pkg, dts_ram and dts_sine_rom
//
// Each input transfer (restart flag) yields exactly one output transfer holding one
// signed 16-bit sample. While a note sounds the sample is (10*s1 + 3*s2)/13 taken from
// the sine table at the phase and at twice the phase, scaled by the attack/decay
// envelope and by the gain; gap samples are zero with active set, and tlast marks the
// final sample of note plus gap. One item is in flight at a time: a sounding sample
// passes the load, rom1, rom2, mix, mag, gain, env and write-back states to reach the
// output register, a gap sample load and write-back, an idle sample load and out. The
// sequence is set by the read-modify-write of the per-note state word in its registered
// memory, the two sine table reads and four passes through the single 32x25 multiplier
// (mix divide, gain, level, envelope decay). The next item is taken while a finished
// sample still waits in the output register. Registers must be written only while no
// item is in flight, not enforced by the block; they take effect on the next sample.
module decaying_tone_synth_core
	import dts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [15:0] sample
	output logic                  m_tlast,
	output logic [0:0]            m_tuser    // [0] active
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOAD = 4'd1;
	localparam logic [3:0] ST_ROM1 = 4'd2;
	localparam logic [3:0] ST_ROM2 = 4'd3;
	localparam logic [3:0] ST_MIX  = 4'd4;
	localparam logic [3:0] ST_MAG  = 4'd5;
	localparam logic [3:0] ST_GAIN = 4'd6;
	localparam logic [3:0] ST_ENV  = 4'd7;
	localparam logic [3:0] ST_WB   = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	// configuration registers
	logic [STEP_W-1:0]  phase_step_q;
	logic [LEN_W-1:0]   note_samples_q;
	logic [LEN_W-1:0]   gap_samples_q;
	logic [DECAY_W-1:0] decay_mult_q;
	logic [GAIN_W-1:0]  gain_q;

	// control
	logic [3:0] st_q;
	logic       running_q;
	logic       m_tvalid_q;

	// working registers
	logic                    restart_q;
	logic [PHASE_W-1:0]      ph_q;
	logic [COUNT_W-1:0]      cnt_q;
	logic [ENV_W-1:0]        env_q;
	logic [ENV_W-1:0]        alvl_q;
	logic [ATT_REM_W-1:0]    arem_q;
	logic                    last_q;
	logic                    sound_q;
	logic                    attack_q;
	logic signed [15:0]      s1_q;
	logic signed [NUM_W-1:0] num_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic [15:0]             res_sample_q;
	logic                    res_active_q;
	logic [15:0]             m_tdata_q;
	logic                    m_tlast_q;
	logic                    m_tuser_q;

	// combinational
	logic                    cfg_wr;
	logic [2:0]              cfg_idx;
	logic                    in_xfer;
	logic                    out_free;
	logic                    out_load;
	logic [COUNT_W-1:0]      note_eff;
	logic [COUNT_W-1:0]      total_m1;
	dts_state_t              ram_rdata;
	dts_state_t              ram_wdata;
	dts_state_t              ld;
	logic                    run;
	logic                    ld_sound;
	logic                    rom_en;
	logic [SINE_IDX_W-1:0]   rom_idx;
	logic signed [15:0]      rom_val;
	logic signed [NUM_W-1:0] s1_ext;
	logic signed [NUM_W-1:0] s2_ext;
	logic [NUM_W-1:0]        num_mag;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [ENV_W-1:0]        prod_hi;
	logic [MAG_W-1:0]        sat_mag;
	logic [ATT_REM_W:0]      arem_sum;
	logic                    arem_carry;
	logic [ATT_REM_W-1:0]    arem_next;
	logic [ENV_W-1:0]        alvl_next;

	// apb write and read decode
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			note_samples_q <= LEN_W'(1);
			gap_samples_q  <= '0;
			decay_mult_q   <= '1;
			gain_q         <= GAIN_W'(45875);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PHASE_STEP:   phase_step_q   <= pwdata[STEP_W-1:0];
				REG_NOTE_SAMPLES: note_samples_q <= pwdata[LEN_W-1:0];
				REG_GAP_SAMPLES:  gap_samples_q  <= pwdata[LEN_W-1:0];
				REG_DECAY_MULT:   decay_mult_q   <= pwdata[DECAY_W-1:0];
				REG_GAIN:         gain_q         <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PHASE_STEP:   prdata = 32'(phase_step_q);
			REG_NOTE_SAMPLES: prdata = 32'(note_samples_q);
			REG_GAP_SAMPLES:  prdata = 32'(gap_samples_q);
			REG_DECAY_MULT:   prdata = 32'(decay_mult_q);
			REG_GAIN:         prdata = 32'(gain_q);
			default:          prdata = '0;
		endcase
	end

	// note length bounds, a zero note length counts as one
	assign note_eff = (note_samples_q == '0) ? COUNT_W'(1) : COUNT_W'(note_samples_q);
	assign total_m1 = note_eff + COUNT_W'(gap_samples_q) - COUNT_W'(1);

	// handshakes
	assign s_tready = (st_q == ST_IDLE);
	assign in_xfer  = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign out_load = ((st_q == ST_WB) || (st_q == ST_OUT)) && out_free;

	// per-note state word, read on acceptance and written back at the end
	dts_ram #(
		.WIDTH($bits(dts_state_t)),
		.DEPTH(1)
	) u_state_ram (
		.clk   (clk),
		.we    (st_q == ST_WB),
		.waddr (1'b0),
		.wdata (ram_wdata),
		.re    (in_xfer),
		.raddr (1'b0),
		.rdata (ram_rdata)
	);

	// restart overrides the stored state
	always_comb begin
		if (restart_q) begin
			ld.phase = '0;
			ld.count = '0;
			ld.env   = ENV_ONE;
			ld.alvl  = '0;
			ld.arem  = '0;
		end else begin
			ld = ram_rdata;
		end
	end

	assign run      = running_q | restart_q;
	assign ld_sound = (ld.count < note_eff);

	// sine lookups: base phase in the load cycle, doubled phase in the cycle after
	assign rom_en  = ((st_q == ST_LOAD) && run && ld_sound) || (st_q == ST_ROM1);
	assign rom_idx = (st_q == ST_ROM1) ? ph_q[PHASE_W-2 -: SINE_IDX_W]
	                                   : ld.phase[PHASE_W-1 -: SINE_IDX_W];

	dts_sine_rom u_sine_rom (
		.clk (clk),
		.en  (rom_en),
		.idx (rom_idx),
		.val (rom_val)
	);

	// harmonic mix numerator 10*s1 + 3*s2
	assign s1_ext  = NUM_W'(s1_q);
	assign s2_ext  = NUM_W'(rom_val);
	assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_MIX: begin
				mul_a = MUL_A_W'(num_mag);
				mul_b = MUL_B_W'(RCP_MIX);
			end
			ST_MAG: begin
				mul_a = MUL_A_W'(prod_q[MIX_SH +: MAG_W]);
				mul_b = MUL_B_W'(gain_q);
			end
			ST_GAIN: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = attack_q ? alvl_q : env_q;
			end
			ST_ENV: begin
				if (!attack_q) begin
					mul_a = MUL_A_W'(env_q);
					mul_b = MUL_B_W'(decay_mult_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// output magnitude after the 40-bit shift, saturated
	assign prod_hi = ENV_W'(prod_q[PROD_W-1:OUT_SH]);
	assign sat_mag = (prod_hi > ENV_W'(32767)) ? '1 : prod_hi[MAG_W-1:0];

	// attack ramp step with exact remainder carry
	assign arem_sum   = {1'b0, arem_q} + (ATT_REM_W+1)'(ATT_R);
	assign arem_carry = (arem_sum >= (ATT_REM_W+1)'(ATTACK_SAMPLES));
	assign arem_next  = arem_carry ? ATT_REM_W'(arem_sum - (ATT_REM_W+1)'(ATTACK_SAMPLES))
	                               : arem_sum[ATT_REM_W-1:0];
	assign alvl_next  = alvl_q + ENV_W'(ATT_Q) + ENV_W'(arem_carry);

	// write-back word; the attack ramp follows the count even outside the note
	always_comb begin
		ram_wdata.phase = ph_q + PHASE_W'(phase_step_q);
		ram_wdata.count = last_q ? cnt_q : (cnt_q + COUNT_W'(1));
		ram_wdata.env   = (sound_q && !attack_q) ? prod_q[MIX_SH +: ENV_W] : env_q;
		ram_wdata.alvl  = (attack_q && !last_q) ? alvl_next : alvl_q;
		ram_wdata.arem  = (attack_q && !last_q) ? arem_next : arem_q;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			running_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (in_xfer) st_q <= ST_LOAD;
				ST_LOAD: begin
					if (!run)
						st_q <= ST_OUT;
					else if (ld_sound)
						st_q <= ST_ROM1;
					else
						st_q <= ST_WB;
				end
				ST_ROM1: st_q <= ST_ROM2;
				ST_ROM2: st_q <= ST_MIX;
				ST_MIX:  st_q <= ST_MAG;
				ST_MAG:  st_q <= ST_GAIN;
				ST_GAIN: st_q <= ST_ENV;
				ST_ENV:  st_q <= ST_WB;
				ST_WB: begin
					running_q <= ~last_q;
					st_q      <= out_free ? ST_IDLE : ST_OUT;
				end
				ST_OUT:  if (out_free) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (in_xfer)
			restart_q <= s_tdata[0];
		case (st_q)
			ST_LOAD: begin
				ph_q         <= ld.phase;
				cnt_q        <= ld.count;
				env_q        <= ld.env;
				alvl_q       <= ld.alvl;
				arem_q       <= ld.arem;
				sound_q      <= ld_sound;
				attack_q     <= (ld.count < COUNT_W'(ATTACK_SAMPLES));
				last_q       <= run & (ld.count >= total_m1);
				res_active_q <= run;
				res_sample_q <= '0;
			end
			ST_ROM1: s1_q <= rom_val;
			ST_ROM2: num_q <= (s1_ext <<< 3) + (s1_ext <<< 1) + (s2_ext <<< 1) + s2_ext;
			ST_MIX:  neg_q <= num_q[NUM_W-1];
			ST_ENV: begin
				res_sample_q <= neg_q ? 16'(-$signed({1'b0, sat_mag}))
				                      : {1'b0, sat_mag};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_sample_q;
			m_tlast_q <= last_q;
			m_tuser_q <= res_active_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/core/dts_ram.sv =====
// generic simple dual-port ram with registered read
// stand-alone, no package needed
module dts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/dts_sine_rom.sv =====
// full-cycle sine lookup folded onto the quarter-wave table, registered read
// depends on dts_pkg for the table and its geometry
module dts_sine_rom
	import dts_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic [SINE_IDX_W-1:0]   idx,
	output logic signed [15:0]      val
);

	logic [1:0]       quad;
	logic [QTR_W-1:0] pos;
	logic [QTR_W:0]   fold;
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;

	// quadrant fold: odd quadrants run backwards, upper half is negative
	assign quad = idx[SINE_IDX_W-1 -: 2];
	assign pos  = idx[QTR_W-1:0];
	assign fold = quad[0] ? ((QTR_W+1)'(QTR_DEPTH) - {1'b0, pos}) : {1'b0, pos};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= SINE_TAB[fold];
			neg_q <= quad[1];
		end
	end

	assign val = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ===== test/decaying_tone_synth_core_tb.sv =====
// testbench for decaying_tone_synth_core: sends restart flags over the input stream, programs
// the registers over apb and checks every output sample against a behavioural tone model
// depends on dts_pkg and the rtl of the synthesiser core
module decaying_tone_synth_core_tb;
	import dts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_ITEMS = 500;
	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int          END_WAIT     = 40;

	localparam longint unsigned STEP_MAX  = 64'h7FFF_FFFF;
	localparam longint unsigned LEN_MAX   = 64'd1048560;
	localparam longint unsigned DECAY_MAX = 64'hFF_FFFF;
	localparam longint unsigned GAIN_MAX  = 64'hFFFF;

	// one expected output transfer
	typedef struct packed {
		logic signed [15:0] pcm;
		logic               is_last;
		logic               is_active;
	} tone_sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] sample
	logic        m_tlast;
	logic [0:0]  m_tuser;        // [0] active

	// full-wave sine table and tone state of the model
	int              sine_wave [SINE_TABLE_DEPTH];
	bit [31:0]       ph_acc;
	bit [COUNT_W-1:0] note_pos;
	longint unsigned env_level;
	bit              note_running;
	longint unsigned cfg_step, cfg_note, cfg_gap, cfg_decay, cfg_gain;

	tone_sample_t    expected_samples [$];
	int              error_count = 0;
	int              items_sent = 0;
	int              burst_left = 1;
	bit              valid_held = 1'b0;
	int unsigned     cycle_count = 0;
	bit [7:0]        stall_pattern = 8'hFF;
	bit [2:0]        stall_pos = '0;

	decaying_tone_synth_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// sine table: quarter wave by integer taylor series in q2.30, mirrored to a full cycle
	function automatic void fill_sine_wave();
		longint unsigned t, t2, term, s, v;
		longint          sum;
		int unsigned     quad, r;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			quad = (4 * k) / SINE_TABLE_DEPTH;
			r    = (4 * k) % SINE_TABLE_DEPTH;
			if (quad & 1)
				r = SINE_TABLE_DEPTH - r;
			t    = (HALF_PI_Q30 * r) / SINE_TABLE_DEPTH;
			t2   = (t * t) >> 30;
			term = t;
			sum  = longint'(t);
			for (int n = 1; n <= 5; n++) begin
				term = ((term * t2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			s = sum;
			if (s > ONE_Q30)
				s = ONE_Q30;
			v = (s * 32767 + (ONE_Q30 >> 1)) >> 30;
			sine_wave[k] = (quad >= 2) ? -int'(v) : int'(v);
		end
	endfunction

	// model state and registers after reset
	function automatic void reset_tone_model();
		cfg_step     = 0;
		cfg_note     = 1;
		cfg_gap      = 0;
		cfg_decay    = DECAY_MAX;
		cfg_gain     = 45875;
		ph_acc       = '0;
		note_pos     = '0;
		env_level    = ENV_ONE;
		note_running = 1'b0;
	endfunction

	// next output sample for one restart flag, advancing the tone state
	function automatic tone_sample_t predict_tone_sample(bit restart);
		tone_sample_t    res;
		longint unsigned note_len, total, level, mag, prod, idx;
		bit [31:0]       doubled;
		int              s1, s2, mix;
		bit              is_end;
		res = '0;
		if (restart) begin
			note_running = 1'b1;
			note_pos     = '0;
			ph_acc       = '0;
			env_level    = ENV_ONE;
		end
		if (!note_running)
			return res;
		note_len = (cfg_note == 0) ? 1 : cfg_note;
		total    = note_len + cfg_gap;
		// sounding part: harmonic mix times envelope times gain
		if (note_pos < note_len) begin
			idx     = ph_acc;
			idx     = (idx * SINE_TABLE_DEPTH) >> 32;
			s1      = sine_wave[idx % SINE_TABLE_DEPTH];
			doubled = ph_acc << 1;
			idx     = doubled;
			idx     = (idx * SINE_TABLE_DEPTH) >> 32;
			s2      = sine_wave[idx % SINE_TABLE_DEPTH];
			mix     = (10 * s1 + 3 * s2) / 13;
			if (note_pos < ATTACK_SAMPLES) begin
				level = note_pos;
				level = (level << 24) / ATTACK_SAMPLES;
			end else begin
				level     = env_level;
				env_level = (env_level * cfg_decay) >> 24;
			end
			mag  = (mix < 0) ? -mix : mix;
			prod = (mag * level * cfg_gain) >> 40;
			if (prod > 32767)
				prod = 32767;
			res.pcm = (mix < 0) ? -16'(prod) : 16'(prod);
		end
		is_end        = (note_pos >= total - 1);
		res.is_last   = is_end;
		res.is_active = 1'b1;
		ph_acc        = ph_acc + 32'(cfg_step);
		if (is_end)
			note_running = 1'b0;
		else
			note_pos = note_pos + 1'b1;
		return res;
	endfunction

	// one input transfer; the sender runs in bursts with idle gaps between them
	task automatic send_restart_flag(input bit restart);
		int idle_gap;
		s_tvalid   <= 1'b1;
		s_tdata    <= {7'd0, restart};
		valid_held  = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_samples.push_back(predict_tone_sample(restart));
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			idle_gap   = $urandom_range(0, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
			if (idle_gap != 0) begin
				s_tvalid   <= 1'b0;
				valid_held  = 1'b0;
				repeat (idle_gap) @(posedge clk);
			end
		end
	endtask

	// stop sending and wait for every outstanding sample
	task automatic settle_stream();
		if (valid_held) begin
			s_tvalid   <= 1'b0;
			valid_held  = 1'b0;
		end
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	// apb write while the core is idle; the model takes the value at the same point
	task automatic write_register(input logic [2:0] idx, input longint unsigned value);
		settle_stream();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_PHASE_STEP:   cfg_step  = value & STEP_MAX;
			REG_NOTE_SAMPLES: cfg_note  = value & 64'hF_FFFF;
			REG_GAP_SAMPLES:  cfg_gap   = value & 64'hF_FFFF;
			REG_DECAY_MULT:   cfg_decay = value & DECAY_MAX;
			REG_GAIN:         cfg_gain  = value & GAIN_MAX;
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// random register value, extremes included, note lengths kept short
	function automatic longint unsigned random_reg_value(logic [2:0] idx);
		int pick;
		pick = $urandom_range(0, 9);
		case (idx)
			REG_PHASE_STEP:
				return (pick == 0) ? 0 : (pick == 1) ? STEP_MAX : ($urandom & STEP_MAX);
			REG_NOTE_SAMPLES:
				return (pick == 0) ? 0 : (pick <= 3) ? $urandom_range(97, 130) :
					$urandom_range(1, 40);
			REG_GAP_SAMPLES:
				return $urandom_range(0, 6);
			REG_DECAY_MULT:
				return (pick == 0) ? 0 : (pick == 1) ? DECAY_MAX :
					(pick == 2) ? ($urandom & DECAY_MAX) : DECAY_MAX - $urandom_range(0, 400000);
			default:
				return (pick == 0) ? 0 : (pick == 1) ? GAIN_MAX : ($urandom & GAIN_MAX);
		endcase
	endfunction

	// receiver stalls on an 8-bit pattern, reloaded each round, sometimes all ready
	always @(posedge clk) begin
		if (stall_pos == 0)
			stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		m_tready  <= stall_pattern[stall_pos];
		stall_pos  = stall_pos + 1'b1;
	end

	// compare each output transfer with the oldest expected sample
	always @(posedge clk) begin
		tone_sample_t want;
		if (m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample, expected none, actual %0d",
					$time, $signed(m_tdata));
				error_count++;
			end else begin
				want = expected_samples.pop_front();
				if (m_tdata !== want.pcm) begin
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$time, want.pcm, $signed(m_tdata));
					error_count++;
				end
				if (m_tlast !== want.is_last) begin
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, want.is_last, m_tlast);
					error_count++;
				end
				if (m_tuser[0] !== want.is_active) begin
					$display("%0t: active mismatch, expected %0b, actual %0b",
						$time, want.is_active, m_tuser[0]);
					error_count++;
				end
			end
		end
	end

	// no note started: zero samples with active low
	task automatic test_idle_output();
		send_restart_flag(1'b0);
		send_restart_flag(1'b0);
	endtask

	// reset settings: silent tone, one-sample note flagged last
	task automatic test_silent_tone();
		send_restart_flag(1'b1);
		send_restart_flag(1'b0);
	endtask

	// note length of zero behaves as one
	task automatic test_zero_note_length();
		write_register(REG_PHASE_STEP, 64'h1234_5678);
		write_register(REG_NOTE_SAMPLES, 0);
		send_restart_flag(1'b1);
		send_restart_flag(1'b1);
		send_restart_flag(1'b0);
	endtask

	// fastest tone, full gain, zero decay, short note with a gap
	task automatic test_register_extremes();
		write_register(REG_PHASE_STEP, STEP_MAX);
		write_register(REG_NOTE_SAMPLES, 4);
		write_register(REG_GAP_SAMPLES, 2);
		write_register(REG_DECAY_MULT, 0);
		write_register(REG_GAIN, GAIN_MAX);
		send_restart_flag(1'b1);
		repeat (6) send_restart_flag(1'b0);
	endtask

	// restart abandons the sounding note
	task automatic test_restart_mid_note();
		write_register(REG_PHASE_STEP, 64'h0100_0000);
		write_register(REG_NOTE_SAMPLES, 5);
		send_restart_flag(1'b1);
		send_restart_flag(1'b0);
		send_restart_flag(1'b1);
		send_restart_flag(1'b0);
	endtask

	// lengths shortened under a running note: count already past the end gives last
	task automatic test_register_change_mid_note();
		write_register(REG_NOTE_SAMPLES, LEN_MAX);
		write_register(REG_GAP_SAMPLES, LEN_MAX);
		send_restart_flag(1'b1);
		send_restart_flag(1'b0);
		send_restart_flag(1'b0);
		write_register(REG_NOTE_SAMPLES, 2);
		write_register(REG_GAP_SAMPLES, 0);
		send_restart_flag(1'b0);
		write_register(REG_NOTE_SAMPLES, 3);
		write_register(REG_GAP_SAMPLES, LEN_MAX);
		send_restart_flag(1'b1);
		repeat (3) send_restart_flag(1'b0);
		write_register(REG_GAP_SAMPLES, 1);
		send_restart_flag(1'b0);
	endtask

	// random voices: mostly whole notes, some abandoned or retuned, some random flags
	task automatic test_random_notes();
		int first_item;
		int mode;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			for (int i = REG_PHASE_STEP; i <= REG_GAIN; i++)
				write_register(3'(i), random_reg_value(3'(i)));
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				repeat ($urandom_range(4, 24))
					send_restart_flag($urandom_range(0, 3) == 0);
			end else begin
				send_restart_flag(1'b1);
				if (mode == 1) begin
					repeat ($urandom_range(0, 20)) send_restart_flag(1'b0);
					send_restart_flag(1'b1);
				end else if (mode == 2) begin
					repeat ($urandom_range(1, 30)) send_restart_flag(1'b0);
					mode = $urandom_range(REG_PHASE_STEP, REG_GAIN);
					write_register(3'(mode), random_reg_value(3'(mode)));
				end
				while (note_running)
					send_restart_flag(1'b0);
				repeat ($urandom_range(0, 2)) send_restart_flag(1'b0);
			end
		end
	endtask

	initial begin
		fill_sine_wave();
		reset_tone_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_output();
		test_silent_tone();
		test_zero_note_length();
		test_register_extremes();
		test_restart_mid_note();
		test_register_change_mid_note();
		test_random_notes();
		settle_stream();
		repeat (END_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
